// ===== design/aavr_pkg.sv =====
// shared types, constants and rounding helpers for the axis-angle rotation core
`timescale 1ns / 1ps
package aavr_pkg;

   // angle constants in Q16.16 degrees
   localparam logic [23:0] HALF_TURN_DEG    = 24'd11796480;
   localparam logic [24:0] TURN_DEG         = 25'd23592960;
   localparam logic [22:0] QUARTER_TURN_DEG = 23'd5898240;
   localparam int unsigned TURN_SHIFT       = 19;

   // pi in Q2.30, and the largest radian magnitude after the fold
   localparam logic [31:0] PI_Q30     = 32'd3373259426;
   localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;

   // reciprocals of 45 for exact small-range division
   localparam logic [14:0] RECIP45_TURN = 15'd23302;     // shift 20
   localparam logic [24:0] RECIP45_RAD  = 25'd23860930;  // shift 30
   localparam logic [5:0]  DIV45        = 6'd45;

   // Q2.30 one and polynomial seeds
   localparam logic signed [33:0] Q30_ONE   = 34'sd1073741824;
   localparam logic signed [33:0] SIN_START = -34'sd26;
   localparam logic signed [33:0] COS_START = -34'sd280;
   localparam int HORNER_STEPS = 5;

   // saturation limits
   localparam logic signed [71:0] SAT_MAX = 72'sd2147483647;
   localparam logic signed [71:0] SAT_MIN = -72'sd2147483648;

   typedef struct packed {
      logic signed [33:0] y;
      logic               flip;
   } angle_type;

   typedef struct packed {
      logic signed [33:0] s;
      logic signed [33:0] c;
   } sincos_type;

   typedef struct packed {
      logic signed [31:0] axis_x;
      logic signed [31:0] axis_y;
      logic signed [31:0] axis_z;
      logic signed [31:0] vec_x;
      logic signed [31:0] vec_y;
      logic signed [31:0] vec_z;
   } geom_type;

   // sine horner addend per step
   function automatic logic signed [33:0] sin_add(input int i);
      logic signed [33:0] k;
      case (i)
         0:       k = 34'sd2956;
         1:       k = -34'sd213040;
         2:       k = 34'sd8947846;
         3:       k = -34'sd178956974;
         default: k = Q30_ONE;
      endcase
      return k;
   endfunction

   // cosine horner addend per step
   function automatic logic signed [33:0] cos_add(input int i);
      logic signed [33:0] k;
      case (i)
         0:       k = 34'sd26586;
         1:       k = -34'sd1491253;
         2:       k = 34'sd44739212;
         3:       k = -34'sd536870912;
         default: k = Q30_ONE;
      endcase
      return k;
   endfunction

   // right shift on the magnitude, round half away from zero
   function automatic logic signed [71:0] rnd_shift(input logic signed [71:0] v,
                                                    input int unsigned s);
      logic [71:0] mag;
      logic [71:0] half;
      half = 72'd1 << (s - 1);
      mag  = v[71] ? 72'(-v) : 72'(v);
      mag  = (mag + half) >> s;
      return v[71] ? $signed(72'd0 - mag) : $signed(mag);
   endfunction

endpackage

// ===== design/axis_angle_vector_rotation_core.sv =====
// top level of the axis-angle vector rotation core
`timescale 1ns / 1ps
// Rotates a Q16.16 vector about a Q2.30 axis by an angle in Q16.16 degrees.
// Request channel (req_valid/req_ready) carries the angle, the axis and the
// vector; the response channel (rsp_valid/rsp_ready) returns the rotated
// vector and a flag that is set when any component was clipped to 32 bits.
// The axis is used exactly as given and is not normalized.
// From acceptance to rsp_valid the pipeline runs turn reduction and radian
// conversion, then the sine/cosine horner pipeline, then the matrix build and
// matrix-vector product. Throughput is one transaction per cycle while rsp_ready
// does not hold the pipeline; the stage count is set by the horner chain, where
// each step takes one multiply stage and one round-and-add stage.
// The whole pipeline advances together: when a response is held because
// rsp_ready is low, req_ready drops and every stage holds its contents, so
// nothing is lost or repeated. An empty output slot never stalls the input.
// Synchronous reset clears all stage valid bits; data registers are not
// reset. The block needs no setup after reset.
module axis_angle_vector_rotation_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_angle_deg,
   input  logic signed [31:0] req_axis_x,
   input  logic signed [31:0] req_axis_y,
   input  logic signed [31:0] req_axis_z,
   input  logic signed [31:0] req_vec_x,
   input  logic signed [31:0] req_vec_y,
   input  logic signed [31:0] req_vec_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_rot_x,
   output logic signed [31:0] rsp_rot_y,
   output logic signed [31:0] rsp_rot_z,
   output logic               rsp_saturated
);
   import aavr_pkg::*;

   localparam int GEOM_DELAY = 20;

   // global advance: hold everything while the output is blocked
   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // angle reduction
   logic      ang_vld;
   angle_type ang;

   aavr_angle u_angle (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .angle_deg (req_angle_deg),
      .out_valid (ang_vld),
      .out       (ang)
   );

   // sine and cosine
   logic       sc_vld;
   sincos_type sc;

   aavr_sincos u_sincos (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (ang_vld),
      .in        (ang),
      .out_valid (sc_vld),
      .out       (sc)
   );

   // axis and vector follow the angle path
   geom_type geom_in;
   geom_type geom_ff [GEOM_DELAY];

   always_comb begin
      geom_in.axis_x = req_axis_x;
      geom_in.axis_y = req_axis_y;
      geom_in.axis_z = req_axis_z;
      geom_in.vec_x  = req_vec_x;
      geom_in.vec_y  = req_vec_y;
      geom_in.vec_z  = req_vec_z;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         geom_ff[0] <= geom_in;
         for (int k = 1; k < GEOM_DELAY; k++) geom_ff[k] <= geom_ff[k-1];
      end
   end

   // matrix and product
   aavr_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sc_vld),
      .sc        (sc),
      .geom      (geom_ff[GEOM_DELAY-1]),
      .out_valid (rsp_valid),
      .rot_x     (rsp_rot_x),
      .rot_y     (rsp_rot_y),
      .rot_z     (rsp_rot_z),
      .saturated (rsp_saturated)
   );

   // no response right after reset
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

   // a clipped flag means some component sits on a limit
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
         (rsp_rot_x == 32'sh7fffffff || rsp_rot_x == 32'sh80000000 ||
          rsp_rot_y == 32'sh7fffffff || rsp_rot_y == 32'sh80000000 ||
          rsp_rot_z == 32'sh7fffffff || rsp_rot_z == 32'sh80000000))
      else $error("saturated flag without clipped component");

   // a blocked response keeps the pipeline from advancing
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(sc) && $stable(ang)))
      else $error("pipeline moved while output blocked");

endmodule

// ===== design/aavr_angle.sv =====
// angle reduction to [-90,90] degrees and exact conversion to Q2.30 radians
`timescale 1ns / 1ps
module aavr_angle (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic signed [31:0] angle_deg,
   output logic               out_valid,
   output aavr_pkg::angle_type out
);
   import aavr_pkg::*;

   // stage 1: nearest turn count via reciprocal multiply
   logic [31:0] a_mag;
   logic [32:0] a_round;
   logic [13:0] n_turn;
   logic [28:0] s1_prod_in, s1_prod_ff;
   logic signed [31:0] s1_angle_ff;
   logic s1_vld_ff;

   always_comb begin
      a_mag      = angle_deg[31] ? 32'(-(33'(angle_deg))) : 32'(angle_deg);
      a_round    = {1'b0, a_mag} + 33'(HALF_TURN_DEG);
      n_turn     = a_round[32:TURN_SHIFT];
      s1_prod_in = 29'(n_turn) * 29'(RECIP45_TURN);
   end

   always_ff @(posedge clock) begin
      if (reset) s1_vld_ff <= 1'b0;
      else if (en) s1_vld_ff <= in_valid;
      if (en) begin
         s1_prod_ff  <= s1_prod_in;
         s1_angle_ff <= angle_deg;
      end
   end

   // stage 2: subtract whole turns, fold into a quarter turn
   logic [8:0]  turns;
   logic [33:0] turn_amt;
   logic signed [34:0] turn_s, r_full, r_fold;
   logic        flip_in;
   logic [22:0] s2_mag_in, s2_mag_ff;
   logic        s2_neg_ff, s2_flip_ff, s2_vld_ff;

   always_comb begin
      turns    = s1_prod_ff[28:20];
      turn_amt = 34'(turns) * 34'(TURN_DEG);
      turn_s   = 35'(turn_amt);
      r_full   = s1_angle_ff[31] ? 35'(s1_angle_ff) + turn_s : 35'(s1_angle_ff) - turn_s;
      flip_in  = 1'b0;
      r_fold   = r_full;
      if (r_full > $signed(35'(QUARTER_TURN_DEG))) begin
         r_fold  = $signed(35'(HALF_TURN_DEG)) - r_full;
         flip_in = 1'b1;
      end else if (r_full < -$signed(35'(QUARTER_TURN_DEG))) begin
         r_fold  = -$signed(35'(HALF_TURN_DEG)) - r_full;
         flip_in = 1'b1;
      end
      s2_mag_in = r_fold[34] ? 23'(-r_fold) : 23'(r_fold);
   end

   always_ff @(posedge clock) begin
      if (reset) s2_vld_ff <= 1'b0;
      else if (en) s2_vld_ff <= s1_vld_ff;
      if (en) begin
         s2_mag_ff  <= s2_mag_in;
         s2_neg_ff  <= r_fold[34];
         s2_flip_ff <= flip_in;
      end
   end

   // stage 3: scale by pi, pre-shift the divisor power of two
   logic [54:0] num;
   logic [36:0] s3_n_ff;
   logic        s3_neg_ff, s3_flip_ff, s3_vld_ff;

   assign num = 55'(s2_mag_ff) * 55'(PI_Q30) + 55'(QUARTER_TURN_DEG);

   always_ff @(posedge clock) begin
      if (reset) s3_vld_ff <= 1'b0;
      else if (en) s3_vld_ff <= s2_vld_ff;
      if (en) begin
         s3_n_ff    <= num[54:18];
         s3_neg_ff  <= s2_neg_ff;
         s3_flip_ff <= s2_flip_ff;
      end
   end

   // stage 4: upper chunk divided by 45
   logic [42:0] ph;
   logic [12:0] s4_qh_ff;
   logic [17:0] s4_nh_ff;
   logic [18:0] s4_nl_ff;
   logic        s4_neg_ff, s4_flip_ff, s4_vld_ff;

   assign ph = 43'(s3_n_ff[36:19]) * 43'(RECIP45_RAD);

   always_ff @(posedge clock) begin
      if (reset) s4_vld_ff <= 1'b0;
      else if (en) s4_vld_ff <= s3_vld_ff;
      if (en) begin
         s4_qh_ff   <= ph[42:30];
         s4_nh_ff   <= s3_n_ff[36:19];
         s4_nl_ff   <= s3_n_ff[18:0];
         s4_neg_ff  <= s3_neg_ff;
         s4_flip_ff <= s3_flip_ff;
      end
   end

   // stage 5: remainder joins lower chunk, second reciprocal multiply
   logic [5:0]  rem_h;
   logic [24:0] nxt;
   logic [49:0] pl_in, s5_pl_ff;
   logic [12:0] s5_qh_ff;
   logic        s5_neg_ff, s5_flip_ff, s5_vld_ff;

   always_comb begin
      rem_h = 6'(s4_nh_ff - 18'(s4_qh_ff * 18'(DIV45)));
      nxt   = {rem_h, s4_nl_ff};
      pl_in = 50'(nxt) * 50'(RECIP45_RAD);
   end

   always_ff @(posedge clock) begin
      if (reset) s5_vld_ff <= 1'b0;
      else if (en) s5_vld_ff <= s4_vld_ff;
      if (en) begin
         s5_pl_ff   <= pl_in;
         s5_qh_ff   <= s4_qh_ff;
         s5_neg_ff  <= s4_neg_ff;
         s5_flip_ff <= s4_flip_ff;
      end
   end

   // stage 6: assemble signed radians
   logic [31:0] y_mag;
   angle_type   out_in, out_ff;
   logic        s6_vld_ff;

   always_comb begin
      y_mag       = {s5_qh_ff, 19'd0} + 32'(s5_pl_ff[49:30]);
      out_in.y    = s5_neg_ff ? -$signed(34'(y_mag)) : $signed(34'(y_mag));
      out_in.flip = s5_flip_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) s6_vld_ff <= 1'b0;
      else if (en) s6_vld_ff <= s5_vld_ff;
      if (en) out_ff <= out_in;
   end

   assign out_valid = s6_vld_ff;
   assign out       = out_ff;

   // folded angle never exceeds a quarter turn
   a_y_bound: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out.y <= HALF_PI_Q30 && out.y >= -HALF_PI_Q30))
      else $error("folded angle out of range");

endmodule

// ===== design/aavr_sincos.sv =====
// pipelined minimax sine and cosine, one horner step per two stages
`timescale 1ns / 1ps
module aavr_sincos (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  aavr_pkg::angle_type  in,
   output logic                 out_valid,
   output aavr_pkg::sincos_type out
);
   import aavr_pkg::*;

   // square of the angle
   logic signed [67:0] sq_in, sq_ff;
   logic signed [33:0] sq_y_ff;
   logic sq_flip_ff, sq_vld_ff;

   assign sq_in = in.y * in.y;

   always_ff @(posedge clock) begin
      if (reset) sq_vld_ff <= 1'b0;
      else if (en) sq_vld_ff <= in_valid;
      if (en) begin
         sq_ff      <= sq_in;
         sq_y_ff    <= in.y;
         sq_flip_ff <= in.flip;
      end
   end

   // rounded square
   logic signed [33:0] y2_ff, y2_y_ff;
   logic y2_flip_ff, y2_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) y2_vld_ff <= 1'b0;
      else if (en) y2_vld_ff <= sq_vld_ff;
      if (en) begin
         y2_ff      <= 34'(rnd_shift(72'(sq_ff), 30));
         y2_y_ff    <= sq_y_ff;
         y2_flip_ff <= sq_flip_ff;
      end
   end

   // horner steps: multiply stage then round-and-add stage
   logic [HORNER_STEPS-1:0] src_v, src_f, mv_ff, mf_ff, av_ff, af_ff;
   logic signed [33:0] src_ts [HORNER_STEPS];
   logic signed [33:0] src_tc [HORNER_STEPS];
   logic signed [33:0] src_y  [HORNER_STEPS];
   logic signed [33:0] src_y2 [HORNER_STEPS];
   logic signed [67:0] sp_ff  [HORNER_STEPS];
   logic signed [67:0] cp_ff  [HORNER_STEPS];
   logic signed [33:0] my_ff  [HORNER_STEPS];
   logic signed [33:0] my2_ff [HORNER_STEPS];
   logic signed [33:0] ts_ff  [HORNER_STEPS];
   logic signed [33:0] tc_ff  [HORNER_STEPS];
   logic signed [33:0] ay_ff  [HORNER_STEPS];
   logic signed [33:0] ay2_ff [HORNER_STEPS];

   for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_step
      if (i == 0) begin : g_first
         assign src_v[i]  = y2_vld_ff;
         assign src_f[i]  = y2_flip_ff;
         assign src_ts[i] = SIN_START;
         assign src_tc[i] = COS_START;
         assign src_y[i]  = y2_y_ff;
         assign src_y2[i] = y2_ff;
      end else begin : g_next
         assign src_v[i]  = av_ff[i-1];
         assign src_f[i]  = af_ff[i-1];
         assign src_ts[i] = ts_ff[i-1];
         assign src_tc[i] = tc_ff[i-1];
         assign src_y[i]  = ay_ff[i-1];
         assign src_y2[i] = ay2_ff[i-1];
      end

      // multiply by the squared angle
      always_ff @(posedge clock) begin
         if (reset) mv_ff[i] <= 1'b0;
         else if (en) mv_ff[i] <= src_v[i];
         if (en) begin
            sp_ff[i]  <= src_ts[i] * src_y2[i];
            cp_ff[i]  <= src_tc[i] * src_y2[i];
            my_ff[i]  <= src_y[i];
            my2_ff[i] <= src_y2[i];
            mf_ff[i]  <= src_f[i];
         end
      end

      // round back to Q2.30 and add the next coefficient
      always_ff @(posedge clock) begin
         if (reset) av_ff[i] <= 1'b0;
         else if (en) av_ff[i] <= mv_ff[i];
         if (en) begin
            ts_ff[i]  <= 34'(rnd_shift(72'(sp_ff[i]), 30)) + sin_add(i);
            tc_ff[i]  <= 34'(rnd_shift(72'(cp_ff[i]), 30)) + cos_add(i);
            ay_ff[i]  <= my_ff[i];
            ay2_ff[i] <= my2_ff[i];
            af_ff[i]  <= mf_ff[i];
         end
      end
   end

   // odd polynomial times the angle
   logic signed [67:0] sf_ff;
   logic signed [33:0] fc_ff;
   logic ff_flip_ff, ff_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) ff_vld_ff <= 1'b0;
      else if (en) ff_vld_ff <= av_ff[HORNER_STEPS-1];
      if (en) begin
         sf_ff      <= ts_ff[HORNER_STEPS-1] * ay_ff[HORNER_STEPS-1];
         fc_ff      <= tc_ff[HORNER_STEPS-1];
         ff_flip_ff <= af_ff[HORNER_STEPS-1];
      end
   end

   // final sine and signed cosine
   sincos_type out_in, out_ff;
   logic out_vld_ff;

   always_comb begin
      out_in.s = 34'(rnd_shift(72'(sf_ff), 30));
      out_in.c = ff_flip_ff ? -fc_ff : fc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else if (en) out_vld_ff <= ff_vld_ff;
      if (en) out_ff <= out_in;
   end

   assign out_valid = out_vld_ff;
   assign out       = out_ff;

endmodule

// ===== design/aavr_rotate.sv =====
// rodrigues matrix build and matrix-vector product with saturation
`timescale 1ns / 1ps
module aavr_rotate (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  aavr_pkg::sincos_type  sc,
   input  aavr_pkg::geom_type    geom,
   output logic                  out_valid,
   output logic signed [31:0]    rot_x,
   output logic signed [31:0]    rot_y,
   output logic signed [31:0]    rot_z,
   output logic                  saturated
);
   import aavr_pkg::*;

   logic signed [31:0] ax [3];
   logic signed [31:0] vin [3];

   assign ax[0]  = geom.axis_x;
   assign ax[1]  = geom.axis_y;
   assign ax[2]  = geom.axis_z;
   assign vin[0] = geom.vec_x;
   assign vin[1] = geom.vec_y;
   assign vin[2] = geom.vec_z;

   // r1: axis squares, cross terms and axis times sine
   logic signed [63:0] p_sq_ff [3];
   logic signed [63:0] p_cr_ff [3];
   logic signed [65:0] p_s_ff  [3];
   logic signed [33:0] r1_omc_ff, r1_c_ff;
   logic signed [31:0] r1_v_ff [3];
   logic r1_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) r1_vld_ff <= 1'b0;
      else if (en) r1_vld_ff <= in_valid;
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            p_sq_ff[k] <= ax[k] * ax[k];
            p_cr_ff[k] <= ax[k] * ax[(k + 1) % 3];
            p_s_ff[k]  <= ax[k] * sc.s;
            r1_v_ff[k] <= vin[k];
         end
         r1_omc_ff <= Q30_ONE - sc.c;
         r1_c_ff   <= sc.c;
      end
   end

   // r2: round products to Q2.30
   logic signed [33:0] sq_ff [3];
   logic signed [33:0] cr_ff [3];
   logic signed [33:0] ps_ff [3];
   logic signed [33:0] r2_omc_ff, r2_c_ff;
   logic signed [31:0] r2_v_ff [3];
   logic r2_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) r2_vld_ff <= 1'b0;
      else if (en) r2_vld_ff <= r1_vld_ff;
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            sq_ff[k]   <= 34'(rnd_shift(72'(p_sq_ff[k]), 30));
            cr_ff[k]   <= 34'(rnd_shift(72'(p_cr_ff[k]), 30));
            ps_ff[k]   <= 34'(rnd_shift(72'(p_s_ff[k]), 30));
            r2_v_ff[k] <= r1_v_ff[k];
         end
         r2_omc_ff <= r1_omc_ff;
         r2_c_ff   <= r1_c_ff;
      end
   end

   // r3: one-minus-cosine products, wrapped to 64 bits
   logic signed [63:0] po_sq_ff [3];
   logic signed [63:0] po_cr_ff [3];
   logic signed [33:0] r3_ps_ff [3];
   logic signed [33:0] r3_c_ff;
   logic signed [31:0] r3_v_ff [3];
   logic r3_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) r3_vld_ff <= 1'b0;
      else if (en) r3_vld_ff <= r2_vld_ff;
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            po_sq_ff[k] <= r2_omc_ff * sq_ff[k];
            po_cr_ff[k] <= r2_omc_ff * cr_ff[k];
            r3_ps_ff[k] <= ps_ff[k];
            r3_v_ff[k]  <= r2_v_ff[k];
         end
         r3_c_ff <= r2_c_ff;
      end
   end

   // r4: matrix entries, row-major
   logic signed [35:0] q_sq [3];
   logic signed [35:0] q_cr [3];
   logic signed [35:0] q_s  [3];
   logic signed [35:0] m_in [9];
   logic signed [35:0] m_ff [9];
   logic signed [31:0] r4_v_ff [3];
   logic r4_vld_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         q_sq[k] = 36'(rnd_shift(72'(po_sq_ff[k]), 30));
         q_cr[k] = 36'(rnd_shift(72'(po_cr_ff[k]), 30));
         q_s[k]  = 36'(r3_ps_ff[k]);
      end
      m_in[0] = q_sq[0] + 36'(r3_c_ff);
      m_in[1] = q_cr[0] - q_s[2];
      m_in[2] = q_cr[2] + q_s[1];
      m_in[3] = q_cr[0] + q_s[2];
      m_in[4] = q_sq[1] + 36'(r3_c_ff);
      m_in[5] = q_cr[1] - q_s[0];
      m_in[6] = q_cr[2] - q_s[1];
      m_in[7] = q_cr[1] + q_s[0];
      m_in[8] = q_sq[2] + 36'(r3_c_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) r4_vld_ff <= 1'b0;
      else if (en) r4_vld_ff <= r3_vld_ff;
      if (en) begin
         m_ff    <= m_in;
         r4_v_ff <= r3_v_ff;
      end
   end

   // r5: entries to Q4.28
   logic signed [33:0] e_ff [9];
   logic signed [31:0] r5_v_ff [3];
   logic r5_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) r5_vld_ff <= 1'b0;
      else if (en) r5_vld_ff <= r4_vld_ff;
      if (en) begin
         for (int i = 0; i < 9; i++) e_ff[i] <= 34'(rnd_shift(72'(m_ff[i]), 2));
         r5_v_ff <= r4_v_ff;
      end
   end

   // r6: entry times vector component, wrapped to 64 bits
   logic signed [63:0] pr_ff [9];
   logic r6_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) r6_vld_ff <= 1'b0;
      else if (en) r6_vld_ff <= r5_vld_ff;
      if (en) begin
         for (int i = 0; i < 9; i++) pr_ff[i] <= e_ff[i] * r5_v_ff[i % 3];
      end
   end

   // r7: round each product to Q32 and sum the row
   logic signed [63:0] sum_in [3];
   logic signed [63:0] sum_ff [3];
   logic r7_vld_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         sum_in[r] = 64'(rnd_shift(72'(pr_ff[r * 3]), 12))
                   + 64'(rnd_shift(72'(pr_ff[r * 3 + 1]), 12))
                   + 64'(rnd_shift(72'(pr_ff[r * 3 + 2]), 12));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) r7_vld_ff <= 1'b0;
      else if (en) r7_vld_ff <= r6_vld_ff;
      if (en) sum_ff <= sum_in;
   end

   // r8: back to Q16.16 with clipping
   logic signed [71:0] o_full [3];
   logic signed [31:0] o_in [3];
   logic signed [31:0] o_ff [3];
   logic sat_in, sat_ff, r8_vld_ff;

   always_comb begin
      sat_in = 1'b0;
      for (int r = 0; r < 3; r++) begin
         o_full[r] = rnd_shift(72'(sum_ff[r]), 16);
         if (o_full[r] > SAT_MAX) begin
            o_in[r] = 32'(SAT_MAX);
            sat_in  = 1'b1;
         end else if (o_full[r] < SAT_MIN) begin
            o_in[r] = 32'(SAT_MIN);
            sat_in  = 1'b1;
         end else begin
            o_in[r] = 32'(o_full[r]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) r8_vld_ff <= 1'b0;
      else if (en) r8_vld_ff <= r7_vld_ff;
      if (en) begin
         o_ff   <= o_in;
         sat_ff <= sat_in;
      end
   end

   assign out_valid = r8_vld_ff;
   assign rot_x     = o_ff[0];
   assign rot_y     = o_ff[1];
   assign rot_z     = o_ff[2];
   assign saturated = sat_ff;

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the axis-angle vector rotation core
`timescale 1ns / 1ps
module testbench;

   // rotation request and rotated-vector record
   typedef struct {
      logic signed [31:0] angle, ax, ay, az, vx, vy, vz;
   } rot_req_type;

   typedef struct {
      logic signed [31:0] rx, ry, rz;
      logic               sat;
   } rot_rsp_type;

   localparam longint TURN      = 64'sd23592960;
   localparam longint HALF_TURN = 64'sd11796480;
   localparam longint QTR_TURN  = 64'sd5898240;
   localparam longint PI30      = 64'sd3373259426;
   localparam longint ONE30     = 64'sd1073741824;
   localparam int     NUM_RANDOM = 800;
   localparam int     LATENCY    = 28;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [31:0] req_angle_deg = '0, req_axis_x = '0, req_axis_y = '0;
   logic signed [31:0] req_axis_z = '0, req_vec_x = '0, req_vec_y = '0, req_vec_z = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_rot_x, rsp_rot_y, rsp_rot_z;
   logic               rsp_saturated;

   rot_req_type pending_reqs[$];
   rot_rsp_type expected_rots[$];
   int       error_count = 0;
   int       rsp_count = 0;
   int       sent_count = 0;
   bit       quiet = 1'b0;
   bit       hold_sender = 1'b0;
   bit       stim_done = 1'b0;
   int       send_gap = 0;
   int       recv_gap = 0;
   int       sat_count = 0;

   axis_angle_vector_rotation_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_angle_deg(req_angle_deg), .req_axis_x(req_axis_x),
      .req_axis_y(req_axis_y), .req_axis_z(req_axis_z),
      .req_vec_x(req_vec_x), .req_vec_y(req_vec_y), .req_vec_z(req_vec_z),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_rot_x(rsp_rot_x), .rsp_rot_y(rsp_rot_y), .rsp_rot_z(rsp_rot_z),
      .rsp_saturated(rsp_saturated)
   );

   // clock generation
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // rounding right shift on the unsigned magnitude, ties away from zero
   function automatic longint round_shift(input longint v, input int s);
      longint unsigned mag;
      mag = (v < 0) ? 64'(-v) : 64'(v);
      mag = (mag + (64'd1 << (s - 1))) >> s;
      return (v < 0) ? -$signed(mag) : $signed(mag);
   endfunction

   function automatic longint mul_q30(input longint a, input longint b);
      return round_shift(a * b, 30);
   endfunction

   function automatic longint rotate_row(input longint m0, m1, m2, vx, vy, vz);
      longint acc;
      acc = round_shift(round_shift(m0, 2) * vx, 12)
          + round_shift(round_shift(m1, 2) * vy, 12)
          + round_shift(round_shift(m2, 2) * vz, 12);
      return round_shift(acc, 16);
   endfunction

   function automatic logic signed [31:0] clip_q16(input longint v, inout logic sat);
      if (v > 64'sd2147483647) begin
         sat = 1'b1;
         return 32'sh7fffffff;
      end
      if (v < -64'sd2147483648) begin
         sat = 1'b1;
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   // rodrigues rotation of one request
   function automatic rot_rsp_type rotate_vector(input rot_req_type q);
      longint a, turns, r, y, y2, t, s, c, omc;
      longint ax, ay, az, vx, vy, vz;
      longint xx, yy, zz, xy, yz, zx, xs, ys, zs, oxy, oyz, ozx;
      longint mag;
      logic   flip;
      rot_rsp_type o;
      a = q.angle; ax = q.ax; ay = q.ay; az = q.az;
      vx = q.vx; vy = q.vy; vz = q.vz;
      flip = 1'b0;
      o.sat = 1'b0;
      // nearest whole turn
      if (a >= 0) turns = (a + HALF_TURN) / TURN;
      else turns = -((-a + HALF_TURN) / TURN);
      r = a - turns * TURN;
      // fold to a quarter turn
      if (r > QTR_TURN) begin
         r = HALF_TURN - r;
         flip = 1'b1;
      end else if (r < -QTR_TURN) begin
         r = -HALF_TURN - r;
         flip = 1'b1;
      end
      mag = (r < 0) ? -r : r;
      mag = (mag * PI30 + QTR_TURN) / HALF_TURN;
      y = (r < 0) ? -mag : mag;
      y2 = mul_q30(y, y);
      // sine and cosine polynomials
      t = -26;
      t = mul_q30(t, y2) + 2956;
      t = mul_q30(t, y2) - 213040;
      t = mul_q30(t, y2) + 8947846;
      t = mul_q30(t, y2) - 178956974;
      t = mul_q30(t, y2) + ONE30;
      s = mul_q30(t, y);
      t = -280;
      t = mul_q30(t, y2) + 26586;
      t = mul_q30(t, y2) - 1491253;
      t = mul_q30(t, y2) + 44739212;
      t = mul_q30(t, y2) - 536870912;
      t = mul_q30(t, y2) + ONE30;
      c = flip ? -t : t;
      omc = ONE30 - c;
      // matrix terms
      xx = mul_q30(ax, ax); yy = mul_q30(ay, ay); zz = mul_q30(az, az);
      xy = mul_q30(ax, ay); yz = mul_q30(ay, az); zx = mul_q30(az, ax);
      xs = mul_q30(ax, s); ys = mul_q30(ay, s); zs = mul_q30(az, s);
      oxy = mul_q30(omc, xy); oyz = mul_q30(omc, yz); ozx = mul_q30(omc, zx);
      o.rx = clip_q16(rotate_row(mul_q30(omc, xx) + c, oxy - zs, ozx + ys, vx, vy, vz),
                      o.sat);
      o.ry = clip_q16(rotate_row(oxy + zs, mul_q30(omc, yy) + c, oyz - xs, vx, vy, vz),
                      o.sat);
      o.rz = clip_q16(rotate_row(ozx - ys, oyz + xs, mul_q30(omc, zz) + c, vx, vy, vz),
                      o.sat);
      return o;
   endfunction

   function automatic rot_req_type make_req(input logic signed [31:0] angle, ax, ay, az,
                                            vx, vy, vz);
      rot_req_type q;
      q.angle = angle; q.ax = ax; q.ay = ay; q.az = az;
      q.vx = vx; q.vy = vy; q.vz = vz;
      return q;
   endfunction

   // random field: mostly plausible values, sometimes full-range
   function automatic logic signed [31:0] rand_field(input int span);
      if ($urandom_range(0, 7) == 0) return $urandom;
      return $signed($urandom_range(0, 2 * span)) - span;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_ready) begin
         // hold the transaction
      end else begin
         if (req_valid) sent_count <= sent_count + 1;
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 15) == 0) begin
            send_gap <= $urandom_range(1, 16);
            req_valid <= 1'b0;
         end else if (!hold_sender && pending_reqs.size() > 0) begin
            rot_req_type q;
            q = pending_reqs.pop_front();
            expected_rots.push_back(rotate_vector(q));
            req_valid <= 1'b1;
            req_angle_deg <= q.angle; req_axis_x <= q.ax; req_axis_y <= q.ay;
            req_axis_z <= q.az; req_vec_x <= q.vx; req_vec_y <= q.vy;
            req_vec_z <= q.vz;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response monitor and receiver stalls
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            rsp_count <= rsp_count + 1;
            if (expected_rots.size() == 0) begin
               $error("unexpected transaction: rot_x=%0d", rsp_rot_x);
               error_count = error_count + 1;
            end else begin
               rot_rsp_type e;
               e = expected_rots.pop_front();
               if (e.sat) sat_count <= sat_count + 1;
               if (rsp_rot_x !== e.rx) begin
                  $error("rot_x expected %0d actual %0d", e.rx, rsp_rot_x);
                  error_count = error_count + 1;
               end
               if (rsp_rot_y !== e.ry) begin
                  $error("rot_y expected %0d actual %0d", e.ry, rsp_rot_y);
                  error_count = error_count + 1;
               end
               if (rsp_rot_z !== e.rz) begin
                  $error("rot_z expected %0d actual %0d", e.rz, rsp_rot_z);
                  error_count = error_count + 1;
               end
               if (rsp_saturated !== e.sat) begin
                  $error("saturated expected %0d actual %0d", e.sat, rsp_saturated);
                  error_count = error_count + 1;
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 15) == 0) begin
            recv_gap <= $urandom_range(1, 16);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // stimulus and end of run
   initial begin
      logic signed [31:0] ang;
      int n_dir;
      // directed: angle extremes, half turns, quarter turns, axis and vector extremes
      pending_reqs.push_back(make_req(0, 32'sh40000000, 0, 0, 32'h10000, 32'h20000, 0));
      pending_reqs.push_back(make_req(32'sh00b40000, 0, 0, 32'sh40000000, 32'h10000, 0, 0));
      pending_reqs.push_back(make_req(-32'sh00b40000, 0, 0, 32'sh40000000, 32'h10000, 0, 0));
      pending_reqs.push_back(make_req(32'sh021c0000, 0, 32'sh40000000, 0, 32'h10000, 0, 32'h30000));
      pending_reqs.push_back(make_req(-32'sh021c0000, 0, 32'sh40000000, 0, 32'h10000, 0, 32'h30000));
      pending_reqs.push_back(make_req(32'sh005a0000, 32'sh40000000, 0, 0, 0, 32'h10000, 0));
      pending_reqs.push_back(make_req(32'sh005a0001, 32'sh40000000, 0, 0, 0, 32'h10000, 0));
      pending_reqs.push_back(make_req(-32'sh005a0001, 32'sh40000000, 0, 0, 0, 32'h10000, 0));
      pending_reqs.push_back(make_req(32'sh7fffffff, 32'sh24f34e8b, 32'sh24f34e8b, 32'sh24f34e8b,
                                      32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
      pending_reqs.push_back(make_req(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                                      32'sh80000000, 32'sh80000000, 32'sh80000000));
      pending_reqs.push_back(make_req(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                                      32'sh7fffffff, 32'sh80000000, 32'sh7fffffff));
      pending_reqs.push_back(make_req(32'sh002d0000, 32'sh7fffffff, 0, 32'sh80000000,
                                      32'sh40000000, 32'sh40000000, 32'sh40000000));
      pending_reqs.push_back(make_req(32'sh00010000, 32'sh20000000, 32'sh20000000, 0,
                                      -32'sh10000, -32'sh7fffffff, 32'h1));
      pending_reqs.push_back(make_req(32'hffffffff, 0, 0, 0, 32'hffffffff, 32'hffffffff, 1));
      n_dir = pending_reqs.size();
      // random: unit-ish axes with moderate vectors, plus wide noise
      repeat (NUM_RANDOM) begin
         ang = ($urandom_range(0, 3) == 0) ? $signed($urandom)
               : rand_field(32'sh02000000);
         pending_reqs.push_back(make_req(ang, rand_field(32'sh40000000),
                                         rand_field(32'sh40000000),
                                         rand_field(32'sh40000000),
                                         rand_field(32'sh10000000),
                                         rand_field(32'sh10000000),
                                         rand_field(32'sh10000000)));
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      // drain once mid-run with the sender held off
      wait (pending_reqs.size() < NUM_RANDOM / 2);
      @(posedge clock);
      hold_sender <= 1'b1;
      wait (expected_rots.size() == 0 && !req_valid);
      @(posedge clock);
      hold_sender <= 1'b0;
      // last part runs without idling
      wait (pending_reqs.size() < 100);
      @(posedge clock);
      quiet <= 1'b1;
      wait (pending_reqs.size() == 0 && !req_valid);
      wait (expected_rots.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      $display("covered %0d directed and %0d random rotations, %0d responses checked",
               n_dir, NUM_RANDOM, rsp_count);
      $display("%0d responses clipped to 32 bits, %0d check failures",
               sat_count, error_count);
      if (error_count == 0 && expected_rots.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
